// ===== sv/b64sc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

  // carry counts (bits held)
  localparam logic [2:0] CNT_NONE = 3'd0;
  localparam logic [2:0] CNT_TWO  = 3'd2;
  localparam logic [2:0] CNT_FOUR = 3'd4;
  localparam logic [2:0] CNT_SIX  = 3'd6;

  // direction register values
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // alphabet anchors
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;

  localparam logic [7:0] SYM_LOWER_BASE = 8'd26;
  localparam logic [7:0] SYM_DIGIT_BASE = 8'd52;
  localparam logic [7:0] SYM_PLUS       = 8'd62;
  localparam logic [7:0] SYM_SLASH      = 8'd63;
  localparam logic [7:0] SYM_BAD        = 8'hff;

  // results of one item: up to two values
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] v0;
    logic [7:0] v1;
    logic       bad;
  } b64sc_res_t;

  // 6-bit symbol to ASCII character
  function automatic logic [7:0] char_of_sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w < SYM_LOWER_BASE)      return CH_UPPER_A + w;
    else if (w < SYM_DIGIT_BASE) return CH_LOWER_A + (w - SYM_LOWER_BASE);
    else if (w < SYM_PLUS)       return CH_DIGIT_0 + (w - SYM_DIGIT_BASE);
    else if (w == SYM_PLUS)      return CH_PLUS;
    else                         return CH_SLASH;
  endfunction

  // ASCII character to symbol, all ones when outside the alphabet
  function automatic logic [7:0] sym_of_char(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z)      return c - CH_UPPER_A;
    else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CH_LOWER_A + SYM_LOWER_BASE;
    else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return c - CH_DIGIT_0 + SYM_DIGIT_BASE;
    else if (c == CH_PLUS)                       return SYM_PLUS;
    else if (c == CH_SLASH)                      return SYM_SLASH;
    else                                         return SYM_BAD;
  endfunction

endpackage

`default_nettype wire

// ===== sv/base64_stream_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the input register, then the result register
// that presents its first result. Throughput: one item per cycle while each item
// gives at most one result and the output is not stalled; an item that gives two
// characters holds back the next item until its second character is taken.
// Reset (rst, synchronous): direction goes to encode, carry cleared, both
// the input register and the two-entry result register empty.

module base64_stream_codec (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_wen,
  input  wire        cfg_wdata,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] in_byte
  input  wire        s_tlast,   // msg_end
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_value
  output logic       m_tlast,   // out_last
  output logic       m_tuser    // [0] bad_char
);

  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   in_end;
  logic [1:0]             out_cnt;
  logic [7:0]             val0, val1;
  logic                   last0, last1;
  logic                   bad0, bad1;
  logic                   take;
  logic                   load;
  logic                   room;
  b64sc_pkg::b64sc_res_t  res;

  b64sc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step      (load),
    .in_byte   (in_byte),
    .msg_end   (in_end),
    .res       (res)
  );

  // handshake
  assign take     = m_tvalid && m_tready;
  assign room     = (out_cnt == 2'd0) || (out_cnt == 2'd1 && take);
  assign load     = in_full && (room || res.n == 2'd0);
  assign s_tready = !in_full || load;

  assign m_tvalid = out_cnt != 2'd0;
  assign m_tdata  = val0;
  assign m_tlast  = last0;
  assign m_tuser  = bad0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  // result register, two entries
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (load && res.n != 2'd0) begin
      out_cnt <= res.n;
    end else if (take) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.n != 2'd0) begin
      val0  <= res.v0;
      last0 <= (res.n == 2'd1);
      bad0  <= res.bad;
      val1  <= res.v1;
      last1 <= 1'b1;
      bad1  <= res.bad;
    end else if (take) begin
      val0  <= val1;
      last0 <= last1;
      bad0  <= bad1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) out_cnt != 2'd3)
    else $error("result register over full");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && res.n != 2'd0 |=> m_tvalid)
    else $error("loaded result not presented");
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    out_cnt == 2'd2 |-> !last0 && last1)
    else $error("last mark misplaced in a result pair");

endmodule

`default_nettype wire

// ===== sv/b64sc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64sc_core (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_wen,
  input  wire                     cfg_wdata,
  input  wire                     step,
  input  wire  [7:0]              in_byte,
  input  wire                     msg_end,
  output b64sc_pkg::b64sc_res_t   res
);

  logic       direction;
  logic [7:0] carry_bits;
  logic [2:0] carry_count;
  logic [7:0] carry_bits_next;
  logic [2:0] carry_count_next;
  logic [7:0] sym;

  assign sym = b64sc_pkg::sym_of_char(in_byte);

  // results and carry update for the item at the input
  always_comb begin
    res              = '0;
    carry_bits_next  = carry_bits;
    carry_count_next = carry_count;
    if (direction == b64sc_pkg::DIR_ENCODE) begin
      unique case (carry_count)
        b64sc_pkg::CNT_TWO: begin
          res.n  = 2'd1;
          res.v0 = b64sc_pkg::char_of_sym({carry_bits[1:0], in_byte[7:4]});
          carry_bits_next  = {4'b0000, in_byte[3:0]};
          carry_count_next = b64sc_pkg::CNT_FOUR;
          if (msg_end) begin
            res.n  = 2'd2;
            res.v1 = b64sc_pkg::char_of_sym({in_byte[3:0], 2'b00});
          end
        end
        b64sc_pkg::CNT_FOUR: begin
          res.n  = 2'd2;
          res.v0 = b64sc_pkg::char_of_sym({carry_bits[3:0], in_byte[7:6]});
          res.v1 = b64sc_pkg::char_of_sym(in_byte[5:0]);
          carry_bits_next  = '0;
          carry_count_next = b64sc_pkg::CNT_NONE;
        end
        default: begin
          res.n  = 2'd1;
          res.v0 = b64sc_pkg::char_of_sym(in_byte[7:2]);
          carry_bits_next  = {6'b000000, in_byte[1:0]};
          carry_count_next = b64sc_pkg::CNT_TWO;
          if (msg_end) begin
            res.n  = 2'd2;
            res.v1 = b64sc_pkg::char_of_sym({in_byte[1:0], 4'b0000});
          end
        end
      endcase
    end else begin
      res.bad = (sym == b64sc_pkg::SYM_BAD);
      unique case (carry_count)
        b64sc_pkg::CNT_TWO: begin
          res.n  = 2'd1;
          res.v0 = {carry_bits[1:0], 6'b000000} | sym;
          carry_bits_next  = '0;
          carry_count_next = b64sc_pkg::CNT_NONE;
        end
        b64sc_pkg::CNT_FOUR: begin
          res.n  = 2'd1;
          res.v0 = {carry_bits[3:0], 4'b0000} | {2'b00, sym[7:2]};
          carry_bits_next  = {6'b000000, sym[1:0]};
          carry_count_next = b64sc_pkg::CNT_TWO;
        end
        b64sc_pkg::CNT_SIX: begin
          res.n  = 2'd1;
          res.v0 = {carry_bits[5:0], 2'b00} | {4'b0000, sym[7:4]};
          carry_bits_next  = {4'b0000, sym[3:0]};
          carry_count_next = b64sc_pkg::CNT_FOUR;
        end
        default: begin
          carry_bits_next  = sym;
          carry_count_next = b64sc_pkg::CNT_SIX;
        end
      endcase
    end
    // message end clears the carry
    if (msg_end) begin
      carry_bits_next  = '0;
      carry_count_next = b64sc_pkg::CNT_NONE;
    end
  end

  // direction and carry registers; a direction write clears the carry
  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= b64sc_pkg::DIR_ENCODE;
      carry_bits  <= '0;
      carry_count <= b64sc_pkg::CNT_NONE;
    end else if (cfg_wen) begin
      direction   <= cfg_wdata;
      carry_bits  <= '0;
      carry_count <= b64sc_pkg::CNT_NONE;
    end else if (step) begin
      carry_bits  <= carry_bits_next;
      carry_count <= carry_count_next;
    end
  end

  a_count_even: assert property (@(posedge clk) disable iff (rst) carry_count[0] == 1'b0)
    else $error("carry count holds an odd number of bits");
  a_decode_one: assert property (@(posedge clk) disable iff (rst)
    direction == b64sc_pkg::DIR_DECODE |-> res.n != 2'd2 && res.n != 2'd3)
    else $error("decode gives more than one byte");
  a_encode_some: assert property (@(posedge clk) disable iff (rst)
    direction == b64sc_pkg::DIR_ENCODE |-> res.n != 2'd0 && !res.bad)
    else $error("encode gives no character or flags a bad character");

endmodule

`default_nettype wire

// ===== tb/base64_stream_codec_tb.sv =====
`timescale 1ns / 1ps

module base64_stream_codec_tb;

  // one output item of the codec
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       bad;
  } codec_out_t;

  // directed row: stimulus plus, where obvious, the outputs typed in
  typedef struct packed {
    logic       dir;
    logic [7:0] data;
    logic       msg_end;
    logic       typed;
    logic [1:0] n;
    logic [7:0] v0;
    logic [7:0] v1;
    logic       bad;
  } dir_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;

  localparam logic ENC = b64sc_pkg::DIR_ENCODE;
  localparam logic DEC = b64sc_pkg::DIR_DECODE;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 88;
  localparam int GAP_PCT   [4] = '{0, 60, 0, 17};
  localparam int STALL_PCT [4] = '{0, 0, 60, 17};

  localparam int NDIR = 22;
  localparam dir_row_t DIRECTED [NDIR] = '{
    // encode from reset: flush after one byte, all-ones bytes
    '{ENC, 8'h00, 1'b1, TYPED, 2'd2, "A",   "A",   1'b0},
    '{ENC, 8'hff, 1'b1, TYPED, 2'd2, "/",   "w",   1'b0},
    '{ENC, 8'hff, 1'b0, TYPED, 2'd1, "/",   8'h0,  1'b0},
    '{ENC, 8'hff, 1'b0, TYPED, 2'd1, "/",   8'h0,  1'b0},
    '{ENC, 8'hff, 1'b0, TYPED, 2'd2, "/",   "/",   1'b0},
    '{ENC, 8'h4d, 1'b0, PRED,  2'd0, 8'h0,  8'h0,  1'b0},
    '{ENC, 8'h61, 1'b1, PRED,  2'd0, 8'h0,  8'h0,  1'b0},
    // decode: first char gives nothing, second completes a byte
    '{DEC, "A",   1'b0, TYPED, 2'd0, 8'h0,  8'h0,  1'b0},
    '{DEC, "A",   1'b1, TYPED, 2'd1, 8'h00, 8'h0,  1'b0},
    '{DEC, "/",   1'b0, TYPED, 2'd0, 8'h0,  8'h0,  1'b0},
    '{DEC, "/",   1'b0, TYPED, 2'd1, 8'hff, 8'h0,  1'b0},
    '{DEC, "/",   1'b0, TYPED, 2'd1, 8'hff, 8'h0,  1'b0},
    '{DEC, "/",   1'b0, TYPED, 2'd1, 8'hff, 8'h0,  1'b0},
    // characters outside the alphabet, each carry depth
    '{DEC, 8'h00, 1'b0, TYPED, 2'd0, 8'h0,  8'h0,  1'b0},
    '{DEC, "=",   1'b0, TYPED, 2'd1, 8'hff, 8'h0,  1'b1},
    '{DEC, 8'hff, 1'b0, TYPED, 2'd1, 8'hff, 8'h0,  1'b1},
    '{DEC, 8'h80, 1'b1, TYPED, 2'd1, 8'hff, 8'h0,  1'b1},
    // bad char with no output: flag is lost
    '{DEC, "@",   1'b1, TYPED, 2'd0, 8'h0,  8'h0,  1'b0},
    // leftover bits dropped at message end
    '{DEC, "+",   1'b0, PRED,  2'd0, 8'h0,  8'h0,  1'b0},
    '{DEC, "9",   1'b0, PRED,  2'd0, 8'h0,  8'h0,  1'b0},
    '{DEC, "z",   1'b1, PRED,  2'd0, 8'h0,  8'h0,  1'b0},
    '{DEC, 8'h60, 1'b1, PRED,  2'd0, 8'h0,  8'h0,  1'b0}
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_wen   = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  base64_stream_codec uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // codec state as the checker sees it
  string      b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [7:0] sym_of [256];
  logic       model_dir;
  logic [7:0] model_carry;
  logic [2:0] model_cnt;
  codec_out_t step_res [2];
  int         step_n;

  codec_out_t codec_out_due [$];
  int         mismatches   = 0;
  int         tx_gap_pct   = 0;
  int         rx_stall_pct = 0;
  logic       rx_hold      = 1'b0;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return b64_alphabet[s];
  endfunction

  task automatic add_res(input logic [7:0] v, input logic bad);
    step_res[step_n] = '{v, 1'b0, bad};
    step_n++;
  endtask

  // outputs caused by one accepted item; updates the carry
  task automatic model_codec_item(input logic [7:0] d, input logic msg_end);
    logic [15:0] acc;
    logic [7:0]  sym;
    step_n = 0;
    if (model_dir == b64sc_pkg::DIR_ENCODE) begin
      case (model_cnt)
        b64sc_pkg::CNT_TWO: begin
          add_res(sextet_char({model_carry[1:0], d[7:4]}), 1'b0);
          model_carry = {4'h0, d[3:0]};
          model_cnt   = b64sc_pkg::CNT_FOUR;
        end
        b64sc_pkg::CNT_FOUR: begin
          add_res(sextet_char({model_carry[3:0], d[7:6]}), 1'b0);
          add_res(sextet_char(d[5:0]), 1'b0);
          model_carry = 8'h00;
          model_cnt   = b64sc_pkg::CNT_NONE;
        end
        default: begin
          add_res(sextet_char(d[7:2]), 1'b0);
          model_carry = {6'h00, d[1:0]};
          model_cnt   = b64sc_pkg::CNT_TWO;
        end
      endcase
      // flush leftover bits, left-aligned
      if (msg_end && model_cnt == b64sc_pkg::CNT_TWO)
        add_res(sextet_char({model_carry[1:0], 4'h0}), 1'b0);
      else if (msg_end && model_cnt == b64sc_pkg::CNT_FOUR)
        add_res(sextet_char({model_carry[3:0], 2'h0}), 1'b0);
    end else begin
      // bad symbol is all ones and is mixed in unmasked
      sym = sym_of[d];
      case (model_cnt)
        b64sc_pkg::CNT_TWO: begin
          acc = ({8'h00, model_carry} << 6) | {8'h00, sym};
          add_res(acc[7:0], sym == b64sc_pkg::SYM_BAD);
          model_carry = 8'h00;
          model_cnt   = b64sc_pkg::CNT_NONE;
        end
        b64sc_pkg::CNT_FOUR: begin
          acc = ({8'h00, model_carry} << 4) | {8'h00, sym >> 2};
          add_res(acc[7:0], sym == b64sc_pkg::SYM_BAD);
          model_carry = {6'h00, sym[1:0]};
          model_cnt   = b64sc_pkg::CNT_TWO;
        end
        b64sc_pkg::CNT_SIX: begin
          acc = ({8'h00, model_carry} << 2) | {8'h00, sym >> 4};
          add_res(acc[7:0], sym == b64sc_pkg::SYM_BAD);
          model_carry = {4'h0, sym[3:0]};
          model_cnt   = b64sc_pkg::CNT_FOUR;
        end
        default: begin
          model_carry = sym;
          model_cnt   = b64sc_pkg::CNT_SIX;
        end
      endcase
    end
    if (msg_end) begin
      model_carry = 8'h00;
      model_cnt   = b64sc_pkg::CNT_NONE;
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endtask

  task automatic queue_step();
    for (int k = 0; k < step_n; k++) codec_out_due.push_back(step_res[k]);
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t ns: %s got %02h, expected %02h", $time, what, got, want);
  endtask

  // offer one item, with random gaps ahead of it, until accepted
  task automatic offer_item(input logic [7:0] d, input logic msg_end);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= msg_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_codec_item(d, msg_end);
  endtask

  // sender idle until every output has arrived and the pipe is empty
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (codec_out_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic v);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    model_dir   = v;
    model_carry = 8'h00;
    model_cnt   = b64sc_pkg::CNT_NONE;
  endtask

  // output side: check each accepted item, then pick the next ready
  always @(posedge clk) begin
    codec_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (codec_out_due.size() == 0) begin
        flag_mismatch("output with nothing due, value", m_tdata, 8'h00);
      end else begin
        e = codec_out_due.pop_front();
        if (m_tdata !== e.value) flag_mismatch("out_value", m_tdata, e.value);
        if (m_tlast !== e.last)
          flag_mismatch("out_last", {7'b0, m_tlast}, {7'b0, e.last});
        if (m_tuser !== e.bad)
          flag_mismatch("bad_char", {7'b0, m_tuser}, {7'b0, e.bad});
      end
    end
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    dir_row_t   row;
    codec_out_t e;
    logic [7:0] d;
    int         ph;

    for (int c = 0; c < 256; c++) sym_of[c] = b64sc_pkg::SYM_BAD;
    for (int s = 0; s < 64; s++) sym_of[b64_alphabet[s]] = s[7:0];

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    model_dir   = b64sc_pkg::DIR_ENCODE;
    model_carry = 8'h00;
    model_cnt   = b64sc_pkg::CNT_NONE;

    // directed rows
    for (int r = 0; r < NDIR; r++) begin
      row = DIRECTED[r];
      if (row.dir != model_dir) write_direction(row.dir);
      offer_item(row.data, row.msg_end);
      if (row.typed) begin
        for (int k = 0; k < row.n; k++) begin
          e.value = (k == 0) ? row.v0 : row.v1;
          e.last  = (k == row.n - 1);
          e.bad   = row.bad;
          codec_out_due.push_back(e);
        end
      end else begin
        queue_step();
      end
    end

    // random phases: direction alternates, idling mode steps every two
    for (ph = 0; ph < PHASES; ph++) begin
      write_direction(ph[0] ? b64sc_pkg::DIR_DECODE : b64sc_pkg::DIR_ENCODE);
      tx_gap_pct   = GAP_PCT[(ph / 2) % 4];
      rx_stall_pct = STALL_PCT[(ph / 2) % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off with the sender still pushing
        if (ph < 2 && i == 20) begin
          fork
            begin
              rx_hold <= 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              rx_hold <= 1'b0;
            end
          join_none
        end
        if (ph < 2 && i == 60) wait_drained();
        // decode: mostly alphabet chars, some arbitrary bytes
        if (model_dir == b64sc_pkg::DIR_DECODE && $urandom_range(99) < 88)
          d = b64_alphabet[$urandom_range(63)];
        else
          d = 8'($urandom_range(255));
        offer_item(d, $urandom_range(7) == 0);
        queue_step();
      end
    end

    wait_drained();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // timeout for a run that hangs: report mismatches and stop
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
